// ===== src/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // operation field codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam int unsigned OpW      = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  // phase counter: 0 idle, else tick number of the next tick beat
  localparam logic [4:0] PHASE_IDLE     = 5'd0;
  localparam logic [4:0] PHASE_FIRST    = 5'd1;
  localparam logic [4:0] PHASE_SHORT_END = 5'd2;
  localparam logic [4:0] PHASE_BITS_END = 5'd15;
  localparam logic [4:0] PHASE_ACK_SET  = 5'd16;
  localparam logic [4:0] PHASE_ACK_CLK  = 5'd17;
  localparam logic [4:0] PHASE_LONG_END = 5'd18;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_START,
    KIND_STOP,
    KIND_WRITE,
    KIND_READ,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             send_ack;
    logic             sda_in;
  } item_t;

endpackage

// ===== src/i2c_master_byte_sequencer.sv =====
// A beat taken at the input is written into the queue, then popped into the registered output.
// Throughput: one beat per clock while the output is not stalled; the sequencer step is a registered update.
// The queue (FifoDepth entries) absorbs output stalls before input ready drops.
// Reset (rst_ni low, asynchronous): idle, SCL and SDA released, queue empty,
// read byte and ACK flag cleared.
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// I2C master line sequencer: start, stop, byte write and byte read commands
// stepped by half-period tick beats.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [i2cm_pkg::InDataW-1:0]  s_axis_tdata,  // data[7:0], send_ack, sda_in
  input  logic [i2cm_pkg::OpW-1:0]      s_axis_tuser,  // operation[2:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [i2cm_pkg::OutDataW-1:0] m_axis_tdata   // scl, sda_drive, busy_res,
                                                       // done_res, rx_data[7:0], ack_seen
);
  import i2cm_pkg::*;

  logic  q_ready, q_push, q_valid, q_pop;
  item_t push_item, pop_item;

  i2cm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  i2cm_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_item_i     (pop_item),
    .in_pop_o      (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done result still reports busy");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("sequencer popped an empty queue");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !q_pop |=> q_valid)
    else $error("queued beat lost without being popped");
`endif

endmodule

// ===== src/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: takes beats from the slave port and decodes the operation.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [i2cm_pkg::InDataW-1:0]      s_axis_tdata,  // data[7:0], send_ack, sda_in
  input  logic [i2cm_pkg::OpW-1:0]          s_axis_tuser,  // operation[2:0]
  input  logic                              q_ready_i,
  output logic                              q_push_o,
  output i2cm_pkg::item_t                   q_item_o
);
  import i2cm_pkg::*;

  kind_e kind;

  always_comb begin
    case (s_axis_tuser)
      OP_TICK:  kind = KIND_TICK;
      OP_START: kind = KIND_START;
      OP_STOP:  kind = KIND_STOP;
      OP_WRITE: kind = KIND_WRITE;
      OP_READ:  kind = KIND_READ;
      default:  kind = KIND_NOP;
    endcase
  end

  assign s_axis_tready      = q_ready_i;
  assign q_push_o           = s_axis_tvalid & q_ready_i;
  assign q_item_o.kind      = kind;
  assign q_item_o.data      = s_axis_tdata[ByteW-1:0];
  assign q_item_o.send_ack  = s_axis_tdata[ByteW];
  assign q_item_o.sda_in    = s_axis_tdata[ByteW+1];

endmodule

// ===== src/i2cm_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cm_fifo
// Short queue of decoded beats between the front and the back.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2cm_pkg::item_t push_item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output i2cm_pkg::item_t pop_item_o
);
  import i2cm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o    = (count_q != FullCnt);
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i & ready_o;
  assign do_pop     = pop_i & valid_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Line sequencer: steps SCL/SDA per beat and registers one result per beat.
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  i2cm_pkg::item_t               in_item_i,
  output logic                          in_pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [i2cm_pkg::OutDataW-1:0] m_axis_tdata
);
  import i2cm_pkg::*;

  logic [4:0]       phase_q, phase_d;
  kind_e            cmd_q, cmd_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             ack_q, ack_d;
  logic             reply_q, reply_d;
  logic [ByteW-1:0] rx_q, rx_d;
  logic             done;
  logic             odd_bit, even_bit, is_last;
  logic             m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  assign in_pop_o = in_valid_i & (~m_valid_q | m_axis_tready);

  assign odd_bit  = phase_q[0] && (phase_q <= PHASE_BITS_END);
  assign even_bit = !phase_q[0] && (phase_q < PHASE_ACK_SET);
  assign is_last  = (cmd_q == KIND_START || cmd_q == KIND_STOP) ?
                    (phase_q >= PHASE_SHORT_END) : (phase_q >= PHASE_LONG_END);

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    reply_d = reply_q;
    rx_d    = rx_q;
    done    = 1'b0;
    if (phase_q == PHASE_IDLE) begin
      if (in_item_i.kind inside {KIND_START, KIND_STOP, KIND_WRITE, KIND_READ}) begin
        cmd_d   = in_item_i.kind;
        phase_d = PHASE_FIRST;
        scl_d   = 1'b1;
        case (in_item_i.kind)
          KIND_START: sda_d = 1'b1;
          KIND_STOP:  sda_d = 1'b0;
          KIND_WRITE: begin
            shift_d = in_item_i.data;
            sda_d   = in_item_i.data[ByteW-1];
          end
          default: begin
            shift_d = '0;
            reply_d = in_item_i.send_ack;
            sda_d   = 1'b1;
          end
        endcase
      end
    end else if (in_item_i.kind == KIND_TICK) begin
      case (cmd_q)
        KIND_START: begin
          if (phase_q == PHASE_FIRST) sda_d = 1'b0;
          else                        scl_d = 1'b0;
        end
        KIND_STOP: begin
          if (phase_q == PHASE_FIRST) sda_d = 1'b1;
        end
        KIND_WRITE: begin
          if (odd_bit) begin
            scl_d = 1'b0;
          end else if (even_bit) begin
            shift_d = {shift_q[ByteW-2:0], 1'b0};
            sda_d   = shift_q[ByteW-2];
            scl_d   = 1'b1;
          end else if (phase_q == PHASE_ACK_SET) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (phase_q == PHASE_ACK_CLK) begin
            ack_d = ~in_item_i.sda_in;
            scl_d = 1'b0;
          end
        end
        default: begin
          if (odd_bit) begin
            shift_d = {shift_q[ByteW-2:0], in_item_i.sda_in};
            scl_d   = 1'b0;
          end else if (even_bit) begin
            scl_d = 1'b1;
          end else if (phase_q == PHASE_ACK_SET) begin
            sda_d = ~reply_q;
            scl_d = 1'b1;
          end else if (phase_q == PHASE_ACK_CLK) begin
            scl_d = 1'b0;
          end else begin
            sda_d = 1'b1;
            rx_d  = shift_q;
          end
        end
      endcase
      if (is_last) begin
        done    = 1'b1;
        phase_d = PHASE_IDLE;
      end else begin
        phase_d = phase_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PHASE_IDLE;
      cmd_q     <= KIND_TICK;
      shift_q   <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      ack_q     <= 1'b0;
      reply_q   <= 1'b0;
      rx_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_pop_o) begin
        phase_q   <= phase_d;
        cmd_q     <= cmd_d;
        shift_q   <= shift_d;
        scl_q     <= scl_d;
        sda_q     <= sda_d;
        ack_q     <= ack_d;
        reply_q   <= reply_d;
        rx_q      <= rx_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      m_data_q <= {3'b000, ack_d, rx_d, done, (phase_d != PHASE_IDLE), sda_d, scl_d};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== tb/i2c_master_byte_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_test
// Self-checking bench for the I2C line sequencer. Start, stop, write and read
// transfers with random line samples, plus stray commands and idle ticks, are
// streamed in. A cycle-free line model predicts SCL, SDA and status for every
// beat, and each output beat is checked field by field. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // unused operation codes, no effect in any state
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam int unsigned NumBeats   = 1050;
  localparam int unsigned LongStall  = 80;
  localparam int unsigned StallAfter = 300;
  localparam int unsigned DrainAfter = 600;

  typedef enum logic [1:0] {
    SDA_RANDOM,
    SDA_LOW,
    SDA_HIGH
  } sda_pattern_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       send_ack;
    logic       sda_in;
    logic       drain;
  } bus_beat_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
  } line_state_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = OP_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  i2c_master_byte_sequencer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // line model
  // --------------------------------------------------------------------------
  logic [4:0] seq_phase   = PHASE_IDLE;
  logic [2:0] seq_cmd     = OP_TICK;
  logic [7:0] shift_q     = '0;
  logic       scl_q       = 1'b1;
  logic       sda_q       = 1'b1;
  logic       ack_q       = 1'b0;
  logic       reply_ack_q = 1'b0;
  logic [7:0] rx_q        = '0;

  int unsigned cmds_done[8];
  int unsigned acks_got;
  int unsigned reads_nacked;

  function automatic line_state_t i2c_line_step(logic [2:0] op, logic [7:0] data,
                                                logic sack, logic sda_in);
    line_state_t res;
    logic [4:0]  t;
    logic [4:0]  last_tick;
    logic        fin;
    fin = 1'b0;
    t   = seq_phase;
    if (seq_phase == PHASE_IDLE) begin
      if (op >= OP_START && op <= OP_READ) begin
        seq_cmd = op;
        scl_q   = 1'b1;
        case (op)
          OP_START: sda_q = 1'b1;
          OP_STOP:  sda_q = 1'b0;
          OP_WRITE: begin
            shift_q = data;
            sda_q   = data[7];
          end
          default: begin
            shift_q     = '0;
            reply_ack_q = sack;
            sda_q       = 1'b1;
          end
        endcase
        seq_phase = PHASE_FIRST;
      end
    end else if (op == OP_TICK) begin
      case (seq_cmd)
        OP_START: begin
          if (t == PHASE_FIRST) sda_q = 1'b0;
          else scl_q = 1'b0;
        end
        OP_STOP: begin
          if (t == PHASE_FIRST) sda_q = 1'b1;
        end
        OP_WRITE: begin
          if (t <= PHASE_BITS_END && t[0]) begin
            scl_q = 1'b0;
          end else if (t < PHASE_ACK_SET) begin
            shift_q = {shift_q[6:0], 1'b0};
            sda_q   = shift_q[7];
            scl_q   = 1'b1;
          end else if (t == PHASE_ACK_SET) begin
            sda_q = 1'b1;
            scl_q = 1'b1;
          end else if (t == PHASE_ACK_CLK) begin
            ack_q = ~sda_in;
            scl_q = 1'b0;
          end
        end
        default: begin
          if (t <= PHASE_BITS_END && t[0]) begin
            shift_q = {shift_q[6:0], sda_in};
            scl_q   = 1'b0;
          end else if (t < PHASE_ACK_SET) begin
            scl_q = 1'b1;
          end else if (t == PHASE_ACK_SET) begin
            sda_q = ~reply_ack_q;
            scl_q = 1'b1;
          end else if (t == PHASE_ACK_CLK) begin
            scl_q = 1'b0;
          end else begin
            sda_q = 1'b1;
            rx_q  = shift_q;
          end
        end
      endcase
      last_tick = (seq_cmd == OP_START || seq_cmd == OP_STOP) ? PHASE_SHORT_END
                                                              : PHASE_LONG_END;
      if (t >= last_tick) begin
        fin       = 1'b1;
        seq_phase = PHASE_IDLE;
        cmds_done[seq_cmd]++;
        if (seq_cmd == OP_WRITE && ack_q) acks_got++;
        if (seq_cmd == OP_READ && !reply_ack_q) reads_nacked++;
      end else begin
        seq_phase = t + 5'd1;
      end
    end
    res.scl  = scl_q;
    res.sda  = sda_q;
    res.busy = (seq_phase != PHASE_IDLE);
    res.done = fin;
    res.rx   = rx_q;
    res.ack  = ack_q;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus store and helpers
  // --------------------------------------------------------------------------
  bus_beat_t   beat_pending_q[$];
  line_state_t line_expect_q[$];
  int unsigned counted_beats;
  int unsigned total_beats;
  int unsigned mismatches;
  bit          drain_placed;
  int unsigned beats_in;
  int unsigned results_out;

  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(99) < 3) begin
      quiet = $urandom_range(60, 20);
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return $urandom_range(1) ? 8'h80 : 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_beat(logic [2:0] op, logic [7:0] data, logic sack, logic sda,
                            logic drain = 1'b0);
    bus_beat_t b;
    b.op       = op;
    b.data     = data;
    b.send_ack = sack;
    b.sda_in   = sda;
    b.drain    = drain;
    beat_pending_q.push_back(b);
  endtask

  // no-effect beat while idle: stray tick or unused code
  task automatic queue_idle_noise();
    logic [2:0] op;
    case ($urandom_range(3))
      0: op = OP_TICK;
      1: op = OP_RSVD_5;
      2: op = OP_RSVD_6;
      default: op = OP_RSVD_7;
    endcase
    queue_beat(op, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // one command and all of its tick beats; noisy inserts ignored commands
  task automatic queue_transfer(logic [2:0] cmd, logic [7:0] data, logic sack,
                                sda_pattern_e pat, bit noisy, logic drain);
    int   n_ticks;
    logic sda;
    n_ticks = (cmd == OP_WRITE || cmd == OP_READ) ? 18 : 2;
    queue_beat(cmd, data, sack, 1'($urandom), drain);
    for (int i = 1; i <= n_ticks; i++) begin
      if (noisy && $urandom_range(9) == 0)
        queue_beat(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom), 1'($urandom));
      case (pat)
        SDA_LOW:  sda = 1'b0;
        SDA_HIGH: sda = 1'b1;
        default:  sda = 1'($urandom);
      endcase
      queue_beat(OP_TICK, 8'($urandom), 1'($urandom), sda);
    end
    counted_beats += n_ticks + 1;
  endtask

  initial begin
    logic [2:0]   cmd;
    sda_pattern_e pat;
    logic         drain;
    int unsigned  r;

    rst_ni = 1'b0;

    // directed: idle no-ops, short commands, a command while busy, write 0x80
    queue_beat(OP_TICK, 8'hFF, 1'b1, 1'b0);
    queue_beat(OP_RSVD_5, 8'h00, 1'b0, 1'b1);
    queue_beat(OP_RSVD_6, 8'hFF, 1'b1, 1'b0);
    queue_beat(OP_RSVD_7, 8'h55, 1'b0, 1'b1);
    queue_beat(OP_START, 8'h00, 1'b0, 1'b1);
    queue_beat(OP_WRITE, 8'hFF, 1'b1, 1'b0);
    queue_beat(OP_TICK, 8'h00, 1'b0, 1'b1);
    queue_beat(OP_TICK, 8'h00, 1'b0, 1'b1);
    queue_beat(OP_STOP, 8'hAA, 1'b1, 1'b0);
    queue_beat(OP_TICK, 8'h00, 1'b0, 1'b1);
    queue_beat(OP_TICK, 8'h00, 1'b0, 1'b1);
    queue_transfer(OP_WRITE, 8'h80, 1'b0, SDA_LOW, 1'b0, 1'b0);

    while (counted_beats < NumBeats) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(3, 1)) queue_idle_noise();
      end else begin
        r = $urandom_range(99);
        if (r < 20) cmd = OP_START;
        else if (r < 40) cmd = OP_STOP;
        else if (r < 70) cmd = OP_WRITE;
        else cmd = OP_READ;
        r = $urandom_range(5);
        pat = (r == 0) ? SDA_LOW : (r == 1) ? SDA_HIGH : SDA_RANDOM;
        drain = ($urandom_range(99) < 2);
        if (!drain_placed && counted_beats >= DrainAfter) begin
          drain        = 1'b1;
          drain_placed = 1'b1;
        end
        queue_transfer(cmd, rand_byte(), 1'($urandom), pat, $urandom_range(99) < 15,
                       drain);
      end
    end
    total_beats = beat_pending_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in != total_beats || results_out != total_beats) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (line_expect_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, line_expect_q.size());
      mismatches++;
    end

    $display("Checked %0d beats: %0d starts, %0d stops, %0d writes, %0d reads completed",
             results_out, cmds_done[OP_START], cmds_done[OP_STOP], cmds_done[OP_WRITE],
             cmds_done[OP_READ]);
    $display("Writes with target ACK: %0d, reads ending in NACK: %0d, mismatches: %0d",
             acks_got, reads_nacked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d of %0d beats checked", $time, results_out, total_beats);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // input driver
  // --------------------------------------------------------------------------
  int unsigned tx_gap;
  int unsigned tx_quiet;
  bus_beat_t   next_beat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_TICK;
      beats_in      <= 0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        line_expect_q.push_back(i2c_line_step(s_axis_tuser, s_axis_tdata[7:0],
                                              s_axis_tdata[8], s_axis_tdata[9]));
        beats_in <= beats_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap        <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (beat_pending_q.size() != 0 &&
                     (!beat_pending_q[0].drain ||
                      beats_in + (s_axis_tvalid && s_axis_tready) == results_out)) begin
          next_beat     = beat_pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, next_beat.sda_in, next_beat.send_ack, next_beat.data};
          s_axis_tuser  <= next_beat.op;
          tx_gap        <= pick_gap(tx_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output side: ready pattern, one long hold-off to back up the block
  // --------------------------------------------------------------------------
  int unsigned rx_gap;
  int unsigned rx_quiet;
  bit          long_hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      rx_gap         <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && beats_in >= StallAfter) begin
      long_hold_done <= 1'b1;
      rx_gap         <= LongStall;
      m_axis_tready  <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap        <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_gap        <= pick_gap(rx_quiet);
    end
  end

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: beat %0d %s mismatch: expected 0x%0h, got 0x%0h",
               $time, results_out, fname, want, got);
      mismatches++;
    end
  endtask

  line_state_t want_line;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      results_out <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      results_out <= results_out + 1;
      if (line_expect_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, got 0x%0h",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        want_line = line_expect_q.pop_front();
        check_field("scl", want_line.scl, m_axis_tdata[0]);
        check_field("sda_drive", want_line.sda, m_axis_tdata[1]);
        check_field("busy", want_line.busy, m_axis_tdata[2]);
        check_field("done", want_line.done, m_axis_tdata[3]);
        check_field("rx_data", want_line.rx, m_axis_tdata[11:4]);
        check_field("ack_seen", want_line.ack, m_axis_tdata[12]);
      end
    end
  end

endmodule
